// File: hdl/hls2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HLS to RGB conversion package
// Shared widths, constants and payload types of the color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hls2rgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = FRAC_BITS;
  localparam int CH_W      = FRAC_BITS + 1;
  localparam int SUM_W     = CH_W + 1;
  localparam int PROD_W    = 2 * CH_W;
  localparam int HUE6_W    = HUE_W + 3;
  localparam int NCH       = 3;

  localparam logic [CH_W-1:0]  ONE   = CH_W'(1) << FRAC_BITS;
  localparam logic [CH_W-1:0]  HALF  = CH_W'(1) << (FRAC_BITS - 1);
  localparam logic [HUE_W-1:0] THIRD = HUE_W'(((1 << FRAC_BITS) + 1) / 3);

  // Piece of the hue ramp that a channel's hue falls on.
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_TOP,
    SEG_FALL,
    SEG_BOTTOM
  } seg_t;

  typedef struct packed {
    seg_t            seg;
    logic [CH_W-1:0] factor;
  } seg_info_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  lightness;
    logic [CH_W-1:0]  saturation;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// File: hdl/hls_to_rgb_convert.sv
// Throughput: one pixel per clock unless rgb_ready holds the output; each of
// the five register stages takes a new pixel when the next moves or is empty.
// Reset: synchronous, active high; clears all stage valid bits, the pipeline
// comes out of reset empty and ready.
// ----------------------------------------------------------------------------
// HLS to RGB color conversion
// Fixed-point HLS to RGB converter, five-stage pipeline with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hls_to_rgb_convert (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     hsl_valid,
  output logic                    hsl_ready,
  input  wire hls2rgb_pkg::hsl_t  hsl,
  output logic                    rgb_valid,
  input  wire                     rgb_ready,
  output hls2rgb_pkg::rgb_t       rgb
);

  import hls2rgb_pkg::*;

  // Classify a hue into its ramp segment and the multiplier for that segment.
  function automatic seg_info_t hue_seg(input logic [HUE_W-1:0] h);
    logic [HUE6_W-1:0] h6;
    logic [HUE6_W-1:0] h3;
    logic [HUE6_W-1:0] fall;
    seg_info_t         info;
    h6   = (HUE6_W'(h) << 2) + (HUE6_W'(h) << 1);
    h3   = (HUE6_W'(h) << 1) + HUE6_W'(h);
    fall = (HUE6_W'(ONE) << 2) - h6;
    info.factor = '0;
    if (h6 < HUE6_W'(ONE)) begin
      info.seg    = SEG_RISE;
      info.factor = h6[CH_W-1:0];
    end else if (h < HALF[HUE_W-1:0]) begin
      info.seg = SEG_TOP;
    end else if (h3 < (HUE6_W'(ONE) << 1)) begin
      info.seg    = SEG_FALL;
      info.factor = fall[CH_W-1:0];
    end else begin
      info.seg = SEG_BOTTOM;
    end
    return info;
  endfunction

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic en1, en2, en3, en4, en5;
  logic v1, v2, v3, v4;

  assign en5       = !rgb_valid || rgb_ready;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign hsl_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (en1) v1 <= hsl_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) rgb_valid <= v4;
    end
  end

  // ---------------- Stage 1: clamp, L*S product, hue segments ----------------
  logic [CH_W-1:0]   l_sat, s_sat;
  logic [HUE_W-1:0]  hue_ch [NCH];
  seg_info_t         seg_next [NCH];

  logic [CH_W-1:0]   l1, s1;
  logic              gray1;
  logic [PROD_W-1:0] ls_prod1;
  seg_info_t         seg1 [NCH];

  always_comb begin
    l_sat     = (hsl.lightness > ONE) ? ONE : hsl.lightness;
    s_sat     = (hsl.saturation > ONE) ? ONE : hsl.saturation;
    // Red leads by a third of a turn, blue trails by one; both wrap.
    hue_ch[0] = hsl.hue + THIRD;
    hue_ch[1] = hsl.hue;
    hue_ch[2] = hsl.hue - THIRD;
    for (int c = 0; c < NCH; c++) begin
      seg_next[c] = hue_seg(hue_ch[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      l1       <= l_sat;
      s1       <= s_sat;
      gray1    <= (s_sat == '0);
      ls_prod1 <= PROD_W'(l_sat) * PROD_W'(s_sat);
      for (int c = 0; c < NCH; c++) begin
        seg1[c] <= seg_next[c];
      end
    end
  end

  // ---------------- Stage 2: m2 ----------------
  logic [CH_W-1:0]  ls;
  logic [SUM_W-1:0] m2_sum;
  logic [CH_W-1:0]  m2_next;

  logic [CH_W-1:0]  l2, m2_2;
  logic             gray2;
  seg_info_t        seg2 [NCH];

  always_comb begin
    ls = ls_prod1[FRAC_BITS +: CH_W];
    if (l1 <= HALF) begin
      m2_sum = SUM_W'(l1) + SUM_W'(ls);
    end else begin
      m2_sum = SUM_W'(l1) + SUM_W'(s1) - SUM_W'(ls);
    end
    m2_next = (m2_sum > SUM_W'(ONE)) ? ONE : m2_sum[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      l2    <= l1;
      m2_2  <= m2_next;
      gray2 <= gray1;
      for (int c = 0; c < NCH; c++) begin
        seg2[c] <= seg1[c];
      end
    end
  end

  // ---------------- Stage 3: m1 and ramp height ----------------
  logic [SUM_W-1:0] two_l;
  logic [SUM_W-1:0] m1_wide;
  logic [CH_W-1:0]  m1_next;
  logic [CH_W-1:0]  d_next;

  logic [CH_W-1:0]  l3, m1_3, m2_3, d3;
  logic             gray3;
  seg_info_t        seg3 [NCH];

  always_comb begin
    two_l   = {l2, 1'b0};
    m1_wide = (two_l >= SUM_W'(m2_2)) ? (two_l - SUM_W'(m2_2)) : '0;
    m1_next = (m1_wide > SUM_W'(ONE)) ? ONE : m1_wide[CH_W-1:0];
    d_next  = (m2_2 >= m1_next) ? (m2_2 - m1_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      l3    <= l2;
      m1_3  <= m1_next;
      m2_3  <= m2_2;
      d3    <= d_next;
      gray3 <= gray2;
      for (int c = 0; c < NCH; c++) begin
        seg3[c] <= seg2[c];
      end
    end
  end

  // ---------------- Stage 4: ramp products ----------------
  logic [CH_W-1:0]   l4, m1_4, m2_4;
  logic              gray4;
  seg_t              seg4 [NCH];
  logic [PROD_W-1:0] ramp_prod4 [NCH];

  always_ff @(posedge clk) begin
    if (en4) begin
      l4    <= l3;
      m1_4  <= m1_3;
      m2_4  <= m2_3;
      gray4 <= gray3;
      for (int c = 0; c < NCH; c++) begin
        seg4[c]       <= seg3[c].seg;
        ramp_prod4[c] <= PROD_W'(d3) * PROD_W'(seg3[c].factor);
      end
    end
  end

  // ---------------- Stage 5: segment select, output register ----------------
  localparam int RAMP_W = PROD_W - FRAC_BITS + 1;

  logic [RAMP_W-1:0] ramp_sum [NCH];
  logic [CH_W-1:0]   ch_next  [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ramp_sum[c] = RAMP_W'(m1_4) + RAMP_W'(ramp_prod4[c][PROD_W-1:FRAC_BITS]);
      case (seg4[c]) inside
        SEG_RISE, SEG_FALL: begin
          ch_next[c] = (ramp_sum[c] > RAMP_W'(ONE)) ? ONE : ramp_sum[c][CH_W-1:0];
        end
        SEG_TOP:    ch_next[c] = m2_4;
        default:    ch_next[c] = m1_4;
      endcase
      if (gray4) begin
        ch_next[c] = l4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      rgb.red   <= ch_next[0];
      rgb.green <= ch_next[1];
      rgb.blue  <= ch_next[2];
    end
  end

endmodule

`default_nettype wire

// File: hdl/hls2rgb_checker.sv
// ----------------------------------------------------------------------------
// HLS to RGB port checker
// Concurrent assertions on the converter's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hls2rgb_checker (
  input wire                     clk,
  input wire                     rst,
  input wire                     hsl_ready,
  input wire                     rgb_valid,
  input wire                     rgb_ready,
  input wire hls2rgb_pkg::rgb_t  rgb
);

  import hls2rgb_pkg::*;

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rgb_valid)
    else $error("rgb_valid high right after reset");

  // When the output stage can move, every stage can, so the input is open.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!rgb_valid || rgb_ready) |-> hsl_ready)
    else $error("input stalled while output stage is free");

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && !rgb_ready) |=> (rgb_valid && $stable(rgb)))
    else $error("rgb transaction dropped or changed while stalled");

  // Channels never exceed full scale.
  a_range: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> (rgb.red <= ONE && rgb.green <= ONE && rgb.blue <= ONE))
    else $error("rgb channel above full scale");

endmodule

bind hls_to_rgb_convert hls2rgb_checker u_hls2rgb_checker (
  .clk       (clk),
  .rst       (rst),
  .hsl_ready (hsl_ready),
  .rgb_valid (rgb_valid),
  .rgb_ready (rgb_ready),
  .rgb       (rgb)
);

`default_nettype wire
